[hdl/delta_timer_queue_unit_macros.svh]
// ----------------------------------------------------------------------------
// Delta timer queue assertion macros
// Shared concurrent assertion forms, clocked on clock and qualified by reset.
// ----------------------------------------------------------------------------
`ifndef DELTA_TIMER_QUEUE_UNIT_MACROS_SVH
`define DELTA_TIMER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DTQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define DTQ_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

[hdl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// Delta timer queue package
// Field widths, command and status codes, and the stored entry type.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int ID_W        = 8;
   localparam int TIME_W      = 16;
   localparam int STAT_W      = 2;
   localparam int COUNT_OUT_W = 5;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] delta;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } mem_wr_type;

endpackage

[hdl/dtq_req_if.sv]
// ----------------------------------------------------------------------------
// Delta timer queue command channel
// Valid/ready channel that carries one add or remove command per item.
// ----------------------------------------------------------------------------
interface dtq_req_if
   import dtq_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [ID_W-1:0]   waiter_id;
   logic [TIME_W-1:0] wait_time;

   modport source (output valid, output cmd, output waiter_id, output wait_time,
                   input ready);
   modport sink   (input valid, input cmd, input waiter_id, input wait_time,
                   output ready);
endinterface

[hdl/dtq_rsp_if.sv]
// ----------------------------------------------------------------------------
// Delta timer queue result channel
// Valid/ready channel that carries one result item per command.
// ----------------------------------------------------------------------------
interface dtq_rsp_if
   import dtq_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [STAT_W-1:0]      status;
   logic [ID_W-1:0]        removed_id;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output removed_id,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input removed_id,
                   input entry_count, output ready);
endinterface

[hdl/dtq_store.sv]
// ----------------------------------------------------------------------------
// Delta timer queue entry store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module dtq_store
   import dtq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic          clock,
   input  mem_wr_type    wr,
   input  logic [IW-1:0] wr_addr,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dtq_ctrl.sv]
// ----------------------------------------------------------------------------
// Delta timer queue controller
// Walks the circular entry store to insert or remove, and holds the result.
// ----------------------------------------------------------------------------
module dtq_ctrl
   import dtq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IW    = 4,
   parameter int CW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   dtq_req_if.sink       req_if,
   dtq_rsp_if.source     rsp_if,
   output mem_wr_type    wr,
   output logic [IW-1:0] wr_addr,
   output logic [IW-1:0] rd_addr,
   input  entry_type     rd_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_CMP    = 4'd2;
   localparam logic [3:0] S_SREAD  = 4'd3;
   localparam logic [3:0] S_SWRITE = 4'd4;
   localparam logic [3:0] S_RM_A   = 4'd5;
   localparam logic [3:0] S_RM_B   = 4'd6;
   localparam logic [3:0] S_RM_C   = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   localparam logic [IW:0] DEPTH_W = (IW+1)'(DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [3:0]              state_ff, state_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [TIME_W-1:0]       rest_ff, rest_in;
   logic [ID_W-1:0]         id_ff, id_in;
   entry_type               carry_ff, carry_in;
   logic [STAT_W-1:0]       res_status_ff, res_status_in;
   logic [ID_W-1:0]         res_id_ff, res_id_in;
   logic [CW-1:0]           res_count_ff, res_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [IW-1:0]           phys_idx;
   logic [IW:0]             phys_sum;
   logic [CW-1:0]           idx_ext;
   logic [CW-1:0]           idx_next;
   logic [TIME_W:0]         head_sum;
   logic [TIME_W-1:0]       head_sat;

   // Logical position to physical address in the circular store.
   always_comb begin
      phys_sum = {1'b0, head_ff} + {1'b0, idx_ff};
      if (phys_sum >= DEPTH_W) begin
         phys_sum = phys_sum - DEPTH_W;
      end
      phys_idx = phys_sum[IW-1:0];
   end

   assign idx_ext  = CW'(idx_ff);
   assign idx_next = idx_ext + CW'(1);
   assign head_sum = {1'b0, rest_ff} + {1'b0, rd_data.delta};
   assign head_sat = head_sum[TIME_W] ? {TIME_W{1'b1}} : head_sum[TIME_W-1:0];

   assign rd_addr = phys_idx;
   assign wr_addr = phys_idx;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rest_in       = rest_ff;
      id_in         = id_ff;
      carry_in      = carry_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_count_in  = rsp_count_ff;
      wr.en         = 1'b0;
      wr.data       = carry_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               idx_in    = '0;
               res_id_in = '0;
               if (req_if.cmd == CMD_ADD) begin
                  id_in    = req_if.waiter_id;
                  rest_in  = req_if.wait_time;
                  carry_in = '{id: req_if.waiter_id, delta: req_if.wait_time};
                  if (count_ff == FULL_COUNT) begin
                     res_status_in = STAT_FULL;
                     res_count_in  = count_ff;
                     state_in      = S_RESP;
                  end else if (count_ff == '0) begin
                     state_in = S_SREAD;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STAT_EMPTY;
                     res_count_in  = '0;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_RM_A;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            idx_in = IW'(idx_next);
            if (rd_data.delta <= rest_ff) begin
               rest_in = rest_ff - rd_data.delta;
               if (idx_next == count_ff) begin
                  carry_in = '{id: id_ff, delta: rest_ff - rd_data.delta};
                  state_in = S_SREAD;
               end else begin
                  state_in = S_READ;
               end
            end else begin
               // New entry goes here; the displaced one carries its delta minus the remainder.
               wr.en    = 1'b1;
               wr.data  = '{id: id_ff, delta: rest_ff};
               carry_in = '{id: rd_data.id, delta: rd_data.delta - rest_ff};
               state_in = S_SREAD;
            end
         end
         S_SREAD: begin
            if (idx_ext == count_ff) begin
               wr.en         = 1'b1;
               count_in      = count_ff + CW'(1);
               res_status_in = STAT_DONE;
               res_count_in  = count_ff + CW'(1);
               state_in      = S_RESP;
            end else begin
               state_in = S_SWRITE;
            end
         end
         S_SWRITE: begin
            wr.en    = 1'b1;
            carry_in = rd_data;
            idx_in   = IW'(idx_next);
            state_in = S_SREAD;
         end
         S_RM_A: begin
            idx_in   = IW'(1);
            state_in = S_RM_B;
         end
         S_RM_B: begin
            res_id_in = rd_data.id;
            rest_in   = rd_data.delta;
            state_in  = S_RM_C;
         end
         S_RM_C: begin
            if (count_ff != CW'(1)) begin
               wr.en   = 1'b1;
               wr.data = '{id: rd_data.id, delta: head_sat};
            end
            head_in       = phys_idx;
            count_in      = count_ff - CW'(1);
            res_status_in = STAT_DONE;
            res_count_in  = count_ff - CW'(1);
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_count_in  = COUNT_OUT_W'(res_count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff       <= rest_in;
      id_ff         <= id_in;
      carry_ff      <= carry_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.removed_id  = rsp_id_ff;
   assign rsp_if.entry_count = rsp_count_ff;

endmodule

[hdl/delta_timer_queue_unit.sv]
// ----------------------------------------------------------------------------
// Delta timer queue unit
// Steps: a rejected add or a remove on an empty queue goes straight from
//   the idle state to the result state; a remove reads the head and the
//   entry behind it before it writes; an add passes and then shifts entries.
// Throughput: one item at a time; the walk over the single-port store sets it.
// Reset: synchronous; empties the queue, the store contents stay undefined.
// ----------------------------------------------------------------------------
module delta_timer_queue_unit
   import dtq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   dtq_req_if.sink   req_if,
   dtq_rsp_if.source rsp_if
);

   // The queue is kept as a circular buffer in one memory. Logical position
   // zero is the head entry and lives at the head pointer; the controller
   // maps every logical position onto a physical address with one add and
   // one compare-and-subtract against DEPTH.
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mem_wr_type    wr;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rd_addr;
   entry_type     rd_data;

   // Each entry holds a waiter id and its wait time relative to the entry
   // in front of it. The read data is registered, so the controller can use a
   // read only in the cycle after its address is set.
   dtq_store #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The controller handles one item at a time. An add reads entries from
   // the head, subtracting each delta that is not larger than the remaining
   // time, so equal totals keep their arrival order. At the first larger
   // delta it writes the new entry in place and then ripples the displaced
   // entries one position toward the tail, the first of them with its delta
   // reduced by the remainder. A remove reads the head and the entry behind
   // it, folds the head delta into the second entry with saturation, and
   // advances the head pointer, so it needs no shifting at all. Whenever a
   // write and a read hit the same entry in one cycle, that read data is
   // never used, so no forwarding is needed. The result goes into an output
   // register, and a new item is taken while that result still waits to be
   // picked up.
   dtq_ctrl #(
      .DEPTH (DEPTH),
      .IW    (IW),
      .CW    (CW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

[hdl/dtq_checker.sv]
// ----------------------------------------------------------------------------
// Delta timer queue port checker
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "delta_timer_queue_unit_macros.svh"

module dtq_checker
   import dtq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STAT_W-1:0]      rsp_status,
   input logic [ID_W-1:0]        rsp_removed_id,
   input logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   // A stalled result keeps its contents until taken.
   `DTQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_removed_id) && $stable(rsp_entry_count), "stalled result changed")

   // A failed command returns no id; only a successful remove sets one.
   `DTQ_ASSERT_IMPL(a_reject_no_id, rsp_valid && rsp_status != STAT_DONE, rsp_removed_id == '0, "failed command returned an id")

   // A remove on an empty queue leaves it empty.
   `DTQ_ASSERT_IMPL(a_empty_count, rsp_valid && rsp_status == STAT_EMPTY, rsp_entry_count == '0, "empty report with entries held")

   // No result right after reset.
   `DTQ_ASSERT_RESET(a_reset_quiet, !rsp_valid, "result shown after reset")

endmodule

bind delta_timer_queue_unit dtq_checker u_dtq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_removed_id  (rsp_if.removed_id),
   .rsp_entry_count (rsp_if.entry_count)
);
